[hw/rtl/bpra_pkg.sv]
// ----------------------------------------------------------------------------
// bpra_pkg
// Shared types and constants of the bitmap page range allocator.
// ----------------------------------------------------------------------------
package bpra_pkg;

  localparam int CNT_W = 13;   // page counts, hints, register widths
  localparam int VW    = 17;   // internal position arithmetic
  localparam int OFS_W = 20;
  localparam int ENT_W = 21;
  localparam int IDX_W = 2;
  localparam int ORD_W = 4;
  localparam int ST_W  = 2;

  localparam logic [CNT_W-1:0] LARGE_RUN_MIN = 13'd16;

  localparam logic [OFS_W-1:0] RST_OFFSET   = 20'd0;
  localparam logic [CNT_W-1:0] RST_ENTRIES  = 13'd4096;
  localparam logic [CNT_W-1:0] RST_HALF     = 13'd3072;
  localparam logic [CNT_W-1:0] RST_BLOCK    = 13'd16;

  localparam logic [IDX_W-1:0] REG_OFFSET  = 2'd0;
  localparam logic [IDX_W-1:0] REG_ENTRIES = 2'd1;
  localparam logic [IDX_W-1:0] REG_HALF    = 2'd2;
  localparam logic [IDX_W-1:0] REG_BLOCK   = 2'd3;

  localparam logic [ST_W-1:0] STAT_OK      = 2'd0;
  localparam logic [ST_W-1:0] STAT_ZERO    = 2'd1;
  localparam logic [ST_W-1:0] STAT_NOSPACE = 2'd2;
  localparam logic [ST_W-1:0] STAT_BADFREE = 2'd3;

  typedef struct packed {
    logic [OFS_W-1:0] offset;
    logic [CNT_W-1:0] size;   // entries in use, capped at the table depth
    logic [CNT_W-1:0] half;   // region boundary, capped at size
    logic [CNT_W-1:0] block;
  } cfg_t;

endpackage

[hw/rtl/bitmap_page_range_allocator_unit.sv]
// ----------------------------------------------------------------------------
// bitmap_page_range_allocator_unit
// Next-fit page run allocator over a one-bit-per-page occupancy RAM.
// ----------------------------------------------------------------------------
// After reset the block sweeps the occupancy RAM clear, one entry a cycle, and
// busy stays high until the sweep ends. An item is taken when start is high
// and busy low; its result appears on done for one cycle and cannot be held
// off. All work goes through the single RAM port: the free scan reads and then
// checks each page probed, the run check reads and checks each page of the
// candidate run, and marking and freeing write one page at a time. A clash in
// the run check resumes the scan past the used page, a run that does not fit
// starts a rescan, and a zero-page alloc returns without touching the RAM.
// The next item is taken only once busy falls again.
module bitmap_page_range_allocator_unit import bpra_pkg::*; #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             action,
  input  logic [CNT_W-1:0] page_count,
  input  logic [ORD_W-1:0] align_log2,
  input  logic [CNT_W-1:0] start_hint,
  input  logic [ENT_W-1:0] release_entry,
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [OFS_W-1:0] cfg_data,
  output logic             done,
  output logic [ST_W-1:0]  status,
  output logic [ENT_W-1:0] alloc_entry,
  output logic [CNT_W-1:0] next_hint
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [VW-1:0] LAST = VW'(TABLE_DEPTH - 1);

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_A0      = 4'd2;
  localparam logic [3:0] S_A1      = 4'd3;
  localparam logic [3:0] S_FIND_RD = 4'd4;
  localparam logic [3:0] S_FIND_CK = 4'd5;
  localparam logic [3:0] S_ALIGN   = 4'd6;
  localparam logic [3:0] S_END     = 4'd7;
  localparam logic [3:0] S_TEST    = 4'd8;
  localparam logic [3:0] S_CHK_RD  = 4'd9;
  localparam logic [3:0] S_CHK_CK  = 4'd10;
  localparam logic [3:0] S_MARK    = 4'd11;
  localparam logic [3:0] S_HINT    = 4'd12;
  localparam logic [3:0] S_F0      = 4'd13;
  localparam logic [3:0] S_F1      = 4'd14;
  localparam logic [3:0] S_FCLR    = 4'd15;

  cfg_t cfg;

  bpra_cfg #(.TABLE_DEPTH(TABLE_DEPTH)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic [3:0]       state;
  logic [VW-1:0]    idx;
  logic [VW-1:0]    limit;
  logic [VW-1:0]    n;
  logic [VW-1:0]    run_end;
  logic [VW-1:0]    mask;
  logic [VW-1:0]    kept;
  logic [VW-1:0]    small_hint;
  logic [VW-1:0]    large_hint;
  logic [1:0]       pass;
  logic             big_run;
  logic [CNT_W-1:0] cnt;
  logic [ORD_W-1:0] order;
  logic [CNT_W-1:0] hint;
  logic [ENT_W-1:0] entry;
  logic             ram_we;
  logic             ram_wdata;
  logic             ram_rdata;
  logic [VW-1:0]    bsv;

  bpra_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (idx[AW-1:0]),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = 1'b0;
    case (state)
      S_INIT: ram_we = 1'b1;
      S_MARK: begin
        ram_we    = (idx != run_end);
        ram_wdata = 1'b1;
      end
      S_FCLR: ram_we = (idx != limit);
      default: ;
    endcase
  end

  always_comb begin
    bsv = VW'(cfg.block);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      idx        <= '0;
      done       <= 1'b0;
      small_hint <= '0;
      large_hint <= VW'(RST_HALF);
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT: begin
          if (idx == LAST) begin
            state <= S_IDLE;
          end
          idx <= idx + 1'b1;
        end
        S_IDLE: begin
          if (start) begin
            cnt   <= page_count;
            order <= align_log2;
            hint  <= start_hint;
            entry <= release_entry;
            state <= action ? S_F0 : S_A0;
          end
        end
        S_A0: begin
          if (cnt == '0) begin
            done        <= 1'b1;
            status      <= STAT_ZERO;
            alloc_entry <= '0;
            next_hint   <= '0;
            state       <= S_IDLE;
          end else begin
            big_run <= (cnt >= LARGE_RUN_MIN);
            pass    <= '0;
            mask    <= (order == '0) ? '0 : ((VW'(1) << order) - 1'b1);
            if (cnt >= LARGE_RUN_MIN) begin
              kept  <= large_hint;
              limit <= VW'(cfg.size);
              idx   <= ((hint != '0 ? VW'(hint) : large_hint) < VW'(cfg.half))
                       ? VW'(cfg.half) : (hint != '0 ? VW'(hint) : large_hint);
            end else begin
              kept  <= small_hint;
              limit <= VW'(cfg.half);
              idx   <= (hint != '0) ? VW'(hint) : small_hint;
            end
            state <= S_A1;
          end
        end
        S_A1: begin
          if (idx >= limit) begin
            idx <= kept;
          end
          state <= S_FIND_RD;
        end
        S_FIND_RD: begin
          if (idx >= limit) begin
            n     <= limit;
            state <= S_ALIGN;
          end else begin
            state <= S_FIND_CK;
          end
        end
        S_FIND_CK: begin
          if (!ram_rdata) begin
            n     <= idx;
            state <= S_ALIGN;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_FIND_RD;
          end
        end
        S_ALIGN: begin
          n     <= (n + mask) & ~mask;
          state <= S_END;
        end
        S_END: begin
          run_end <= n + VW'(cnt);
          state   <= S_TEST;
        end
        S_TEST: begin
          if (run_end >= limit) begin
            if (pass != 2'd2) begin
              // rescan: first the same region from its bottom, then from the bottom of the other up to the table size
              idx   <= (big_run ^ pass[0]) ? VW'(cfg.half) : '0;
              limit <= (pass != '0) ? VW'(cfg.size) : limit;
              pass  <= pass + 1'b1;
              state <= S_FIND_RD;
            end else begin
              done        <= 1'b1;
              status      <= STAT_NOSPACE;
              alloc_entry <= '0;
              next_hint   <= '0;
              state       <= S_IDLE;
            end
          end else begin
            idx   <= n;
            state <= S_CHK_RD;
          end
        end
        S_CHK_RD: begin
          if (idx == run_end) begin
            idx   <= n;
            state <= S_MARK;
          end else begin
            state <= S_CHK_CK;
          end
        end
        S_CHK_CK: begin
          idx <= idx + 1'b1;
          state <= ram_rdata ? S_FIND_RD : S_CHK_RD;
        end
        S_MARK: begin
          if (idx == run_end) begin
            state <= S_HINT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_HINT: begin
          if (big_run) begin
            large_hint <= run_end;
          end else begin
            small_hint <= (run_end + bsv - 1'b1) & ~(bsv - 1'b1);
          end
          done        <= 1'b1;
          status      <= STAT_OK;
          alloc_entry <= ENT_W'(n) + ENT_W'(cfg.offset);
          next_hint   <= run_end[CNT_W-1:0];
          state       <= S_IDLE;
        end
        S_F0: begin
          if (entry < ENT_W'(cfg.offset)) begin
            done        <= 1'b1;
            status      <= STAT_BADFREE;
            alloc_entry <= '0;
            next_hint   <= '0;
            state       <= S_IDLE;
          end else begin
            entry <= entry - ENT_W'(cfg.offset);
            state <= S_F1;
          end
        end
        S_F1: begin
          // one extra bit so a run near the top of the entry space cannot wrap
          if (({1'b0, entry} + (ENT_W+1)'(cnt)) > (ENT_W+1)'(cfg.size)) begin
            done        <= 1'b1;
            status      <= STAT_BADFREE;
            alloc_entry <= '0;
            next_hint   <= '0;
            state       <= S_IDLE;
          end else begin
            idx   <= VW'(entry);
            limit <= VW'(entry) + VW'(cnt);
            state <= S_FCLR;
          end
        end
        S_FCLR: begin
          if (idx == limit) begin
            done        <= 1'b1;
            status      <= STAT_OK;
            alloc_entry <= '0;
            next_hint   <= '0;
            state       <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/bpra_ram.sv]
// ----------------------------------------------------------------------------
// bpra_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module bpra_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hw/rtl/bpra_cfg.sv]
// ----------------------------------------------------------------------------
// bpra_cfg
// Configuration registers and the effective table size and region boundary.
// ----------------------------------------------------------------------------
module bpra_cfg import bpra_pkg::*; #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [OFS_W-1:0] cfg_data,
  output cfg_t             cfg
);

  localparam logic [VW-1:0] DEPTH_V = VW'(TABLE_DEPTH);

  logic [OFS_W-1:0] offset;
  logic [CNT_W-1:0] entries;
  logic [CNT_W-1:0] half;
  logic [CNT_W-1:0] block;
  logic [CNT_W-1:0] size;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset  <= RST_OFFSET;
      entries <= RST_ENTRIES;
      half    <= RST_HALF;
      block   <= RST_BLOCK;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_OFFSET:  offset  <= cfg_data;
        REG_ENTRIES: entries <= cfg_data[CNT_W-1:0];
        REG_HALF:    half    <= cfg_data[CNT_W-1:0];
        REG_BLOCK:   block   <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    size = (VW'(entries) > DEPTH_V) ? DEPTH_V[CNT_W-1:0] : entries;
  end

  always_ff @(posedge clk) begin
    cfg.offset <= offset;
    cfg.size   <= size;
    cfg.half   <= (half > size) ? size : half;
    cfg.block  <= block;
  end

endmodule
